// ----- hw/rtl/cpu_exec_pkg.sv -----
// shared types and constants for the cpu execute unit
package cpu_exec_pkg;

    localparam logic [3:0] FZ = 4'b1000;
    localparam logic [3:0] FN = 4'b0100;
    localparam logic [3:0] FH = 4'b0010;
    localparam logic [3:0] FC = 4'b0001;

    localparam logic [7:0] OP_HALT = 8'h76;
    localparam logic [7:0] OP_JP   = 8'hC3;

    // one decoded instruction word between front and back
    typedef struct packed {
        logic [7:0]  op;
        logic [15:0] imm;
        logic [7:0]  mem;
    } t_instr;

endpackage

// ----- hw/rtl/cpu_exec_front.sv -----
// input stage: takes instruction words into a two-entry queue
module cpu_exec_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cpu_exec_pkg::t_instr  i_instr,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cpu_exec_pkg::t_instr  o_instr
);
    cpu_exec_pkg::t_instr r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_instr = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wr] <= i_instr;
                r_wr      <= ~r_wr;
            end
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- hw/rtl/cpu_exec_back.sv -----
// execute stage: register file, alu and registered result word
module cpu_exec_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cpu_exec_pkg::t_instr i_instr,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [119:0]         o_data
);
    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [3:0]  r_f;
    logic [15:0] r_sp, r_pc;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [3:0]  n_f;
    logic [15:0] n_sp, n_pc;
    logic        r_ov;
    logic [119:0] r_out;

    logic        wr, wide, unsup;
    logic [15:0] addr, wdata;
    logic [4:0]  cyc;
    logic        fire;

    assign o_ready = !r_ov || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    function automatic logic [15:0] pair_rd(input logic [1:0] p, input logic [7:0] b,
        input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
        input logic [7:0] h, input logic [7:0] l, input logic [15:0] sp);
        case (p)
            2'd0: pair_rd = {b, c};
            2'd1: pair_rd = {d, e};
            2'd2: pair_rd = {h, l};
            default: pair_rd = sp;
        endcase
    endfunction

    always_comb begin
        logic [7:0]  op, d8, mem, v, r8, srcv;
        logic [2:0]  y, z;
        logic [1:0]  p;
        logic        q, take, cin, cc;
        logic [15:0] hl, pv, off, tmp;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [8:0]  s9;
        logic [4:0]  s5;
        op = i_instr.op; d8 = i_instr.imm[7:0]; mem = i_instr.mem;
        y = op[5:3]; z = op[2:0]; p = y[2:1]; q = y[0];
        hl = {r_h, r_l};
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_f = r_f; n_sp = r_sp;
        n_pc = r_pc + 16'd1;
        wr = 1'b0; wide = 1'b0; addr = '0; wdata = '0; cyc = 5'd4; unsup = 1'b0;
        take = 1'b0; off = '0; v = '0; r8 = '0; tmp = '0;
        s17 = '0; s13 = '0; s9 = '0; s5 = '0; cin = r_f[0]; cc = 1'b0; pv = '0;
        case (z)
            3'd0: srcv = r_b;
            3'd1: srcv = r_c;
            3'd2: srcv = r_d;
            3'd3: srcv = r_e;
            3'd4: srcv = r_h;
            3'd5: srcv = r_l;
            3'd6: srcv = mem;
            default: srcv = r_a;
        endcase
        case (y)
            3'd0: v = r_b;
            3'd1: v = r_c;
            3'd2: v = r_d;
            3'd3: v = r_e;
            3'd4: v = r_h;
            3'd5: v = r_l;
            3'd6: v = mem;
            default: v = r_a;
        endcase
        if (op < 8'h40) begin
            case (z)
                3'd0: begin
                    if (y == 3'd1) begin
                        wr = 1'b1; wide = 1'b1; addr = i_instr.imm; wdata = r_sp;
                        cyc = 5'd20; n_pc = r_pc + 16'd3;
                    end else if (y == 3'd2) begin
                        n_pc = r_pc + 16'd2;
                    end else if (y != 3'd0) begin
                        off = {{8{d8[7]}}, d8};
                        case (y)
                            3'd3: take = 1'b1;
                            3'd4: take = !r_f[3];
                            3'd5: take = r_f[3];
                            3'd6: take = !r_f[0];
                            default: take = r_f[0];
                        endcase
                        n_pc = r_pc + 16'd2 + (take ? off : 16'd0);
                        cyc = take ? 5'd12 : 5'd8;
                    end
                end
                3'd1: begin
                    if (!q) begin
                        tmp = i_instr.imm; cyc = 5'd12; n_pc = r_pc + 16'd3;
                    end else begin
                        pv  = pair_rd(p, r_b, r_c, r_d, r_e, r_h, r_l, r_sp);
                        s17 = {1'b0, hl} + {1'b0, pv};
                        s13 = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
                        n_f = {r_f[3], 1'b0, s13[12], s17[16]};
                        n_h = s17[15:8]; n_l = s17[7:0]; cyc = 5'd8;
                    end
                    if (!q) begin
                        case (p)
                            2'd0: begin n_b = tmp[15:8]; n_c = tmp[7:0]; end
                            2'd1: begin n_d = tmp[15:8]; n_e = tmp[7:0]; end
                            2'd2: begin n_h = tmp[15:8]; n_l = tmp[7:0]; end
                            default: n_sp = tmp;
                        endcase
                    end
                end
                3'd2: begin
                    addr = (p[1]) ? hl : pair_rd(p, r_b, r_c, r_d, r_e, r_h, r_l, r_sp);
                    cyc = 5'd8;
                    if (!q) begin wr = 1'b1; wdata = {8'd0, r_a}; end
                    else n_a = mem;
                    if (p == 2'd2) tmp = hl + 16'd1;
                    else tmp = hl - 16'd1;
                    if (p[1]) begin n_h = tmp[15:8]; n_l = tmp[7:0]; end
                end
                3'd3: begin
                    pv  = pair_rd(p, r_b, r_c, r_d, r_e, r_h, r_l, r_sp);
                    tmp = q ? pv - 16'd1 : pv + 16'd1;
                    cyc = 5'd8;
                    case (p)
                        2'd0: begin n_b = tmp[15:8]; n_c = tmp[7:0]; end
                        2'd1: begin n_d = tmp[15:8]; n_e = tmp[7:0]; end
                        2'd2: begin n_h = tmp[15:8]; n_l = tmp[7:0]; end
                        default: n_sp = tmp;
                    endcase
                end
                3'd4, 3'd5: begin
                    if (z == 3'd4) begin
                        r8 = v + 8'd1;
                        n_f = {r8 == 8'd0, 1'b0, v[3:0] == 4'hF, r_f[0]};
                    end else begin
                        r8 = v - 8'd1;
                        n_f = {r8 == 8'd0, 1'b1, v[3:0] == 4'h0, r_f[0]};
                    end
                    if (y == 3'd6) begin
                        addr = hl; wr = 1'b1; wdata = {8'd0, r8}; cyc = 5'd12;
                    end
                end
                3'd6: begin
                    n_pc = r_pc + 16'd2; r8 = d8; cyc = 5'd8;
                    if (y == 3'd6) begin
                        addr = hl; wr = 1'b1; wdata = {8'd0, d8}; cyc = 5'd12;
                    end
                end
                default: begin
                    case (y)
                        3'd0: begin n_a = {r_a[6:0], r_a[7]}; n_f = {3'd0, r_a[7]}; end
                        3'd1: begin n_a = {r_a[0], r_a[7:1]}; n_f = {3'd0, r_a[0]}; end
                        3'd2: begin n_a = {r_a[6:0], cin}; n_f = {3'd0, r_a[7]}; end
                        3'd3: begin n_a = {cin, r_a[7:1]}; n_f = {3'd0, r_a[0]}; end
                        3'd4: ;
                        3'd5: begin n_a = ~r_a; n_f = r_f | cpu_exec_pkg::FN
                                  | cpu_exec_pkg::FH; end
                        3'd6: n_f = {r_f[3], 3'b001};
                        default: n_f = {r_f[3], 2'b00, ~cin};
                    endcase
                end
            endcase
            if ((z == 3'd4 || z == 3'd5 || z == 3'd6) && y != 3'd6) begin
                case (y)
                    3'd0: n_b = r8;
                    3'd1: n_c = r8;
                    3'd2: n_d = r8;
                    3'd3: n_e = r8;
                    3'd4: n_h = r8;
                    3'd5: n_l = r8;
                    default: n_a = r8;
                endcase
                if (z != 3'd6) cyc = 5'd4;
            end
        end else if (op < 8'h80) begin
            if (op == cpu_exec_pkg::OP_HALT) begin
                cyc = 5'd4;
            end else if (y == 3'd6) begin
                addr = hl; wr = 1'b1; wdata = {8'd0, srcv}; cyc = 5'd8;
            end else begin
                if (z == 3'd6) begin addr = hl; cyc = 5'd8; end
                case (y)
                    3'd0: n_b = srcv;
                    3'd1: n_c = srcv;
                    3'd2: n_d = srcv;
                    3'd3: n_e = srcv;
                    3'd4: n_h = srcv;
                    3'd5: n_l = srcv;
                    default: n_a = srcv;
                endcase
            end
        end else if (op < 8'hC0) begin
            if (z == 3'd6) begin addr = hl; cyc = 5'd8; end
            case (y)
                3'd0, 3'd1: begin
                    cc  = (y == 3'd1) ? cin : 1'b0;
                    s9  = {1'b0, r_a} + {1'b0, srcv} + {8'd0, cc};
                    s5  = {1'b0, r_a[3:0]} + {1'b0, srcv[3:0]} + {4'd0, cc};
                    n_a = s9[7:0];
                    n_f = {s9[7:0] == 8'd0, 1'b0, s5[4], s9[8]};
                end
                3'd2, 3'd3, 3'd7: begin
                    cc  = (y == 3'd3) ? cin : 1'b0;
                    s9  = {1'b0, r_a} - {1'b0, srcv} - {8'd0, cc};
                    s5  = {1'b0, r_a[3:0]} - {1'b0, srcv[3:0]} - {4'd0, cc};
                    if (y != 3'd7) n_a = s9[7:0];
                    n_f = {s9[7:0] == 8'd0, 1'b1, s5[4], s9[8]};
                end
                3'd4: begin n_a = r_a & srcv; n_f = {(r_a & srcv) == 8'd0, 3'b010}; end
                3'd5: begin n_a = r_a ^ srcv; n_f = {(r_a ^ srcv) == 8'd0, 3'b000}; end
                default: begin n_a = r_a | srcv; n_f = {(r_a | srcv) == 8'd0, 3'b000}; end
            endcase
        end else if (op == cpu_exec_pkg::OP_JP) begin
            n_pc = i_instr.imm; cyc = 5'd16;
        end else begin
            unsup = 1'b1; cyc = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_f <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0;
            r_h <= '0; r_l <= '0; r_sp <= '0; r_pc <= '0; r_ov <= 1'b0;
        end else begin
            if (fire) begin
                r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c; r_d <= n_d;
                r_e <= n_e; r_h <= n_h; r_l <= n_l; r_sp <= n_sp; r_pc <= n_pc;
                r_out <= {4'd0, unsup, n_h, n_l, n_d, n_e, n_b, n_c, n_f, n_a, n_pc,
                          cyc, wdata, addr, wide, wr};
            end
            if (o_ready) r_ov <= fire;
        end
    end
endmodule

// ----- hw/rtl/eight_bit_cpu_execute_unit_top.sv -----
// top level of the cpu execute unit: front queue and execute stage
// path: a word passes the queue register and then the result register before it leaves
// throughput: one instruction word per cycle while m_axis_tready does not stall the output
// reset: synchronous active-low, clears all cpu registers, pc and the queue
module eight_bit_cpu_execute_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // mode[7:0], immediate[23:8], mem_data[31:24]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata    // mem_write, mem_wide, mem_addr, mem_wdata,
                                         // cycle_cost, next_pc, acc_out, flags_out,
                                         // bc_out, de_out, hl_out, unsupported, zero pad
);
    cpu_exec_pkg::t_instr in_w, q_w;
    logic q_valid, q_ready;

    // instruction word from the stream
    assign in_w.op  = s_axis_tdata[7:0];
    assign in_w.imm = s_axis_tdata[23:8];
    assign in_w.mem = s_axis_tdata[31:24];

    cpu_exec_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_instr(in_w),
        .o_valid(q_valid), .i_ready(q_ready), .o_instr(q_w)
    );

    cpu_exec_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_instr(q_w),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule
